FILE: hw/rtl/cms_pkg.sv
`timescale 1ns / 1ps

package cms_pkg;

	localparam int MAX_ROWS_D     = 4;
	localparam int MAX_WIDTH_D    = 1024;
	localparam int COUNTER_BITS_D = 32;
	localparam int N_SALTS        = 4;

	localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;

	typedef enum logic [1:0] {
		FUNC_INC = 2'd0,
		FUNC_QRY = 2'd1,
		FUNC_CLR = 2'd2,
		FUNC_NOP = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_ROW_COUNT      = 3'd0,
		REG_ROW_WIDTH      = 3'd1,
		REG_CLEAR_INTERVAL = 3'd2,
		REG_SALT_0         = 3'd3,
		REG_SALT_1         = 3'd4,
		REG_SALT_2         = 3'd5,
		REG_SALT_3         = 3'd6
	} reg_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CRC,
		ST_DIV,
		ST_RD,
		ST_UPD,
		ST_CHK,
		ST_SWEEP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]                row_count;
		logic [10:0]               row_width;
		logic [63:0]               clear_interval;
		logic [N_SALTS-1:0][31:0]  salt;
	} cfg_t;

	typedef struct packed {
		func_t       op;
		logic [31:0] key;
		logic [63:0] now;
	} cmd_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in);
		logic [31:0] c;
		c = c_in;
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CRC32C_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/count_min_sketch_engine.sv
// Sequence: increment/query run, per active row, a CRC32C over the salted key, the remainder
// unit, a counter read and an update; clear runs a check, and a wipe of the store when due.
// Throughput: one transaction in service at a time; a 2-entry queue and an output register
// decouple the input and output sides.
// Reset: asynchronous; afterwards a clearing pass over all MAX_ROWS*MAX_WIDTH counters (4096
// at defaults) zeroes the counter store while no input transaction is taken.
`timescale 1ns / 1ps

module count_min_sketch_engine #(
	parameter int MAX_ROWS     = cms_pkg::MAX_ROWS_D,
	parameter int MAX_WIDTH    = cms_pkg::MAX_WIDTH_D,
	parameter int COUNTER_BITS = cms_pkg::COUNTER_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // key_hash[31:0], now_time[95:32]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // min_count[31:0]
	output logic        m_tuser    // cleared
);

	cms_pkg::cfg_t cfg_q;
	cms_pkg::cmd_t q_data;
	logic          q_valid;
	logic          q_pop;
	logic          init_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count      <= 3'd4;
			cfg_q.row_width      <= 11'd1024;
			cfg_q.clear_interval <= 64'd0;
			cfg_q.salt           <= '0;
		end else if (cfg_we) begin
			case (cms_pkg::reg_t'(cfg_index))
				cms_pkg::REG_ROW_COUNT:      cfg_q.row_count      <= cfg_wdata[2:0];
				cms_pkg::REG_ROW_WIDTH:      cfg_q.row_width      <= cfg_wdata[10:0];
				cms_pkg::REG_CLEAR_INTERVAL: cfg_q.clear_interval <= cfg_wdata;
				cms_pkg::REG_SALT_0:         cfg_q.salt[0]        <= cfg_wdata[31:0];
				cms_pkg::REG_SALT_1:         cfg_q.salt[1]        <= cfg_wdata[31:0];
				cms_pkg::REG_SALT_2:         cfg_q.salt[2]        <= cfg_wdata[31:0];
				cms_pkg::REG_SALT_3:         cfg_q.salt[3]        <= cfg_wdata[31:0];
				default: begin
				end
			endcase
		end
	end

	cms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.init_busy (init_busy),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop)
	);

	cms_back #(
		.MAX_ROWS     (MAX_ROWS),
		.MAX_WIDTH    (MAX_WIDTH),
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	a_clear_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("clear result carries a count");

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !s_tready && !m_tvalid)
		else $error("transaction during clearing pass");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule

FILE: hw/rtl/cms_front.sv
`timescale 1ns / 1ps

module cms_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [95:0]   s_tdata,
	input  logic [1:0]    s_tuser,
	input  logic          init_busy,
	output logic          q_valid,
	output cms_pkg::cmd_t q_data,
	input  logic          q_pop
);

	cms_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	cms_pkg::cmd_t cmd_in;

	always_comb begin
		cmd_in.key = s_tdata[31:0];
		cmd_in.now = s_tdata[95:32];
		cmd_in.op  = cms_pkg::func_t'(s_tuser);
	end

	assign s_tready = (count_q != 2'd2) && !init_busy;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign q_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop && q_valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/cms_div.sv
`timescale 1ns / 1ps

module cms_div #(
	parameter int WW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [WW-1:0] divisor,
	output logic          done,
	output logic [WW-1:0] rem
);

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	logic [31:0]   dvd_q;
	logic [WW-1:0] rem_q;
	logic [WW:0]   trial;
	logic          ge;

	assign trial = {rem_q, dvd_q[31]};
	assign ge    = trial >= {1'b0, divisor};
	assign done  = done_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
			dvd_q  <= 32'd0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
				dvd_q  <= dividend;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= ge ? WW'(trial - {1'b0, divisor}) : WW'(trial);
				dvd_q <= {dvd_q[30:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/cms_back.sv
`timescale 1ns / 1ps

module cms_back #(
	parameter int MAX_ROWS     = cms_pkg::MAX_ROWS_D,
	parameter int MAX_WIDTH    = cms_pkg::MAX_WIDTH_D,
	parameter int COUNTER_BITS = cms_pkg::COUNTER_BITS_D
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cms_pkg::cfg_t cfg,
	input  logic          q_valid,
	input  cms_pkg::cmd_t q_data,
	output logic          q_pop,
	output logic          init_busy,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic          m_tuser
);

	localparam int DEPTH = MAX_ROWS * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int CW    = (WW > 11) ? WW : 11;
	localparam int RCW   = (RW > 3) ? RW : 3;

	cms_pkg::state_t state_q, state_d;

	logic [COUNTER_BITS-1:0] mem [DEPTH];
	logic [COUNTER_BITS-1:0] rd_q;
	logic                    mem_we;
	logic                    mem_re;
	logic [AW-1:0]           mem_waddr;
	logic [COUNTER_BITS-1:0] mem_wdata;

	cms_pkg::cmd_t           cmd_q;
	logic [RW-1:0]           row_q;
	logic [RW-1:0]           rows_q;
	logic [WW-1:0]           width_q;
	logic [AW-1:0]           base_q;
	logic [AW-1:0]           slot_q;
	logic [AW-1:0]           sweep_q;
	logic [31:0]             crc_q;
	logic [1:0]              crc_cnt_q;
	logic [COUNTER_BITS-1:0] min_q;
	logic                    cleared_q;
	logic [63:0]             last_q;
	logic                    out_valid_q;
	logic [31:0]             out_data_q;
	logic                    out_user_q;

	logic [CW-1:0]  w_ext;
	logic [WW-1:0]  w_use;
	logic [RCW-1:0] r_ext;
	logic [RW-1:0]  rows_use;
	logic [RW-1:0]  row_next;
	logic [63:0]    elapsed;
	logic           clear_due;
	logic [63:0]    min_ext;
	logic [31:0]    min_out;
	logic [31:0]    crc_next;
	logic           div_start;
	logic           div_done;
	logic [WW-1:0]  div_rem;
	logic           out_load;

	always_comb begin
		w_ext = CW'(cfg.row_width);
		if (w_ext == '0) begin
			w_use = WW'(1);
		end else if (w_ext > CW'(MAX_WIDTH)) begin
			w_use = WW'(MAX_WIDTH);
		end else begin
			w_use = WW'(w_ext);
		end
		r_ext    = RCW'(cfg.row_count);
		rows_use = (r_ext > RCW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(r_ext);
	end

	assign row_next  = row_q + RW'(1);
	assign elapsed   = cmd_q.now - last_q;
	assign clear_due = (last_q != 64'd0) && (elapsed >= cfg.clear_interval);
	assign min_ext   = 64'(min_q);
	assign min_out   = (min_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : min_ext[31:0];
	assign crc_next  = cms_pkg::crc_byte(crc_q);
	assign init_busy = (state_q == cms_pkg::ST_INIT);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;

	cms_div #(.WW(WW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (crc_next),
		.divisor  (width_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			cms_pkg::ST_INIT, cms_pkg::ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				if (sweep_q == AW'(DEPTH - 1)) begin
					state_d = (state_q == cms_pkg::ST_INIT) ? cms_pkg::ST_IDLE : cms_pkg::ST_OUT;
				end
			end
			cms_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_data.op)
						cms_pkg::FUNC_INC, cms_pkg::FUNC_QRY: begin
							state_d = (rows_use == '0) ? cms_pkg::ST_OUT : cms_pkg::ST_CRC;
						end
						cms_pkg::FUNC_CLR: state_d = cms_pkg::ST_CHK;
						default:           state_d = cms_pkg::ST_OUT;
					endcase
				end
			end
			cms_pkg::ST_CRC: begin
				if (crc_cnt_q == 2'd3) begin
					div_start = 1'b1;
					state_d   = cms_pkg::ST_DIV;
				end
			end
			cms_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = cms_pkg::ST_RD;
				end
			end
			cms_pkg::ST_RD: begin
				mem_re  = 1'b1;
				state_d = cms_pkg::ST_UPD;
			end
			cms_pkg::ST_UPD: begin
				if (cmd_q.op == cms_pkg::FUNC_INC && !(&rd_q)) begin
					mem_we    = 1'b1;
					mem_wdata = rd_q + COUNTER_BITS'(1);
				end
				state_d = (row_next == rows_q) ? cms_pkg::ST_OUT : cms_pkg::ST_CRC;
			end
			cms_pkg::ST_CHK: begin
				state_d = clear_due ? cms_pkg::ST_SWEEP : cms_pkg::ST_OUT;
			end
			cms_pkg::ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = cms_pkg::ST_IDLE;
				end
			end
			default: state_d = cms_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cms_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= '0;
			row_q       <= '0;
			rows_q      <= '0;
			width_q     <= WW'(1);
			base_q      <= '0;
			slot_q      <= '0;
			sweep_q     <= '0;
			crc_q       <= 32'd0;
			crc_cnt_q   <= 2'd0;
			min_q       <= '0;
			cleared_q   <= 1'b0;
			last_q      <= 64'd0;
			out_valid_q <= 1'b0;
			out_data_q  <= 32'd0;
			out_user_q  <= 1'b0;
		end else begin
			case (state_q)
				cms_pkg::ST_INIT, cms_pkg::ST_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
				end
				cms_pkg::ST_IDLE: begin
					if (q_valid) begin
						cmd_q     <= q_data;
						row_q     <= '0;
						rows_q    <= rows_use;
						width_q   <= w_use;
						base_q    <= '0;
						crc_q     <= cfg.salt[0] ^ q_data.key;
						crc_cnt_q <= 2'd0;
						min_q     <= '0;
						cleared_q <= 1'b0;
					end
				end
				cms_pkg::ST_CRC: begin
					crc_q     <= crc_next;
					crc_cnt_q <= crc_cnt_q + 2'd1;
				end
				cms_pkg::ST_DIV: begin
					if (div_done) begin
						slot_q <= base_q + AW'(div_rem);
					end
				end
				cms_pkg::ST_UPD: begin
					if (cmd_q.op == cms_pkg::FUNC_QRY && (row_q == '0 || rd_q < min_q)) begin
						min_q <= rd_q;
					end
					row_q     <= row_next;
					base_q    <= base_q + AW'(width_q);
					crc_q     <= cfg.salt[2'(row_next)] ^ cmd_q.key;
					crc_cnt_q <= 2'd0;
				end
				cms_pkg::ST_CHK: begin
					sweep_q <= '0;
					if (last_q == 64'd0) begin
						last_q <= cmd_q.now;
					end else if (clear_due) begin
						last_q    <= cmd_q.now;
						cleared_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= min_out;
				out_user_q  <= cleared_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
